// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define WMVF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define WMVF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/wmvf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wmvf_pkg;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int CLASS_W = 4;
    localparam int COUNT_W = 8;
    localparam int IDLE_W  = 16;

    // ids at or above this limit never enter the window
    localparam logic [CLASS_W-1:0] ACCEPT_LIMIT = 4'd5;

    // idle timeout after reset
    localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd5;

    // idle counter ceiling
    localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;

    // input beat function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_DET    = 2'd0,
        FUNC_REPORT = 2'd1,
        FUNC_TICK   = 2'd2
    } t_func;

    // result kind codes
    localparam logic KIND_VOTE = 1'b0;
    localparam logic KIND_NONE = 1'b1;

    // vote engine status toward the top level
    typedef struct packed {
        logic               done;
        logic [CLASS_W-1:0] best;
    } t_vote_sts;

endpackage

`default_nettype wire

// File: rtl/core/wmvf_vote.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wmvf_vote #(
    parameter int WINDOW      = 10,
    parameter int NUM_CLASSES = 11
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic [$clog2(WINDOW)-1:0]         o_rd_idx,
    input  wire logic [wmvf_pkg::CLASS_W-1:0] i_rd_data,
    output wmvf_pkg::t_vote_sts               o_sts
);
    import wmvf_pkg::*;

    localparam int WIDX_W = $clog2(WINDOW);
    localparam int CIDX_W = $clog2(NUM_CLASSES);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    typedef enum logic [2:0] {
        V_IDLE  = 3'b001,
        V_TALLY = 3'b010,
        V_SCAN  = 3'b100
    } t_vstate;

    t_vstate           r_vstate;
    logic [CNT_W-1:0]  r_tally [NUM_CLASSES];
    logic [WIDX_W-1:0] r_idx;
    logic [CIDX_W-1:0] r_k;
    logic [CIDX_W-1:0] r_best;
    logic [CNT_W-1:0]  r_best_cnt;

    logic              in_range;
    logic [CNT_W-1:0]  tally_rd;
    logic              better;
    logic              last_k;

    // entry counts only when it names a known class
    assign in_range = {1'b0, i_rd_data} < (CLASS_W + 1)'(NUM_CLASSES);
    assign tally_rd = r_tally[r_k];
    assign better   = tally_rd > r_best_cnt;
    assign last_k   = r_k == CIDX_W'(NUM_CLASSES - 1);
    assign o_rd_idx = r_idx;

    // report the winner on the last scan step; strict compare keeps the lowest class
    always_comb begin
        o_sts.done = (r_vstate == V_SCAN) && last_k;
        o_sts.best = CLASS_W'(better ? r_k : r_best);
    end

    // tally one window entry a cycle, then scan one class a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vstate <= V_IDLE;
        end else begin
            case (r_vstate)
                V_IDLE: begin
                    if (i_start) begin
                        for (int c = 0; c < NUM_CLASSES; c++) begin
                            r_tally[c] <= '0;
                        end
                        r_idx    <= '0;
                        r_vstate <= V_TALLY;
                    end
                end
                V_TALLY: begin
                    if (in_range) begin
                        r_tally[i_rd_data[CIDX_W-1:0]] <=
                            r_tally[i_rd_data[CIDX_W-1:0]] + 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == WIDX_W'(WINDOW - 1)) begin
                        r_k        <= '0;
                        r_best     <= '0;
                        r_best_cnt <= '0;
                        r_vstate   <= V_SCAN;
                    end
                end
                V_SCAN: begin
                    if (better) begin
                        r_best     <= r_k;
                        r_best_cnt <= tally_rd;
                    end
                    if (last_k) begin
                        r_vstate <= V_IDLE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: begin
                    r_vstate <= V_IDLE;
                end
            endcase
        end
    end

    `WMVF_ASSERT(a_vstate_onehot, i_clk, i_rst_n, $onehot(r_vstate), "vote state not one-hot")
    `WMVF_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> r_vstate == V_IDLE, "start while busy")
    `WMVF_ASSERT(a_done_then_idle, i_clk, i_rst_n, o_sts.done |=> r_vstate == V_IDLE, "no return to idle")

endmodule

`default_nettype wire

// File: rtl/core/windowed_mode_vote_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_func, i_class_id, i_object_count
// result    out        o_out_valid / i_out_stall    o_result_kind, o_voted_class
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (idle timeout)
//
// Ticks, reports without timeout and ids without a vote leave the input free; a timeout
// stalls it until the result moves out. An id that fills the window stalls the input
// while the vote engine tallies one window entry a cycle, then scans one class a cycle
// through its single counter and comparator.
// Reset is synchronous and active low; it clears window, fill and idle counts.
// A result waits while the output register holds a stalled result; input stays stalled until it moves out.

`include "assert_macros.svh"

module windowed_mode_vote_filter_unit #(
    parameter int WINDOW      = 10,
    parameter int NUM_CLASSES = 11
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [wmvf_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [wmvf_pkg::CLASS_W-1:0] i_class_id,
    input  wire logic [wmvf_pkg::COUNT_W-1:0] i_object_count,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_result_kind,
    output logic [wmvf_pkg::CLASS_W-1:0]      o_voted_class,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [wmvf_pkg::IDLE_W-1:0]  i_cfg_data
);
    import wmvf_pkg::*;

    localparam int WIDX_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_VOTE = 3'b010,
        S_PEND = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CLASS_W-1:0]  r_win [WINDOW];
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic [IDLE_W-1:0]   r_idle;
    logic [IDLE_W-1:0]   r_timeout;
    logic                r_pend_kind;
    logic [CLASS_W-1:0]  r_pend_class;
    logic                r_out_valid;
    logic                r_out_kind;
    logic [CLASS_W-1:0]  r_out_class;

    logic                in_acc;
    logic                det_ok;
    logic                vote_start;
    logic [IDLE_W-1:0]   idle_eff;
    logic                timed_out;
    logic                out_free;
    logic [WIDX_W-1:0]   rd_idx;
    t_vote_sts           vote_sts;

    assign o_in_stall    = r_state != S_IDLE;
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_voted_class = r_out_class;

    // decode the accepted beat
    assign in_acc     = i_in_valid && !o_in_stall;
    assign det_ok     = (i_func == FUNC_DET) && (i_class_id < ACCEPT_LIMIT);
    assign n_fill     = (r_fill < FILL_W'(WINDOW)) ? r_fill + 1'b1 : r_fill;
    assign vote_start = in_acc && det_ok && (n_fill == FILL_W'(WINDOW));
    assign idle_eff   = (i_object_count != '0) ? '0 : r_idle;
    assign timed_out  = (i_func == FUNC_REPORT) && (idle_eff > r_timeout);
    assign out_free   = !r_out_valid || !i_out_stall;

    wmvf_vote #(
        .WINDOW      (WINDOW),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_vote (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (vote_start),
        .o_rd_idx  (rd_idx),
        .i_rd_data (r_win[rd_idx]),
        .o_sts     (vote_sts)
    );

    // sequence: idle, wait for the vote, hold the result until the output is free
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (vote_start) begin
                    n_state = S_VOTE;
                end else if (in_acc && timed_out) begin
                    n_state = S_PEND;
                end
            end
            S_VOTE: begin
                if (vote_sts.done) begin
                    n_state = S_PEND;
                end
            end
            S_PEND: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // advance window, counters and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_idle    <= '0;
            r_timeout <= TIMEOUT_RESET;
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            if (in_acc && det_ok) begin
                for (int k = 0; k < WINDOW - 1; k++) begin
                    r_win[k] <= r_win[k + 1];
                end
                r_win[WINDOW - 1] <= i_class_id;
                r_fill            <= n_fill;
            end
            if (in_acc && (i_func == FUNC_REPORT) && (i_object_count != '0)) begin
                r_idle <= '0;
            end
            if (in_acc && (i_func == FUNC_TICK) && (r_idle != IDLE_MAX)) begin
                r_idle <= r_idle + 1'b1;
            end
        end
    end

    // hold the pending result
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc && timed_out) begin
            r_pend_kind  <= KIND_NONE;
            r_pend_class <= '0;
        end else if (r_state == S_VOTE && vote_sts.done) begin
            r_pend_kind  <= KIND_VOTE;
            r_pend_class <= vote_sts.best;
        end
    end

    // output register: load a pending result, drop a beat once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PEND && out_free) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= r_pend_kind;
            r_out_class <= r_pend_class;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    `WMVF_ASSERT(a_state_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `WMVF_ASSERT(a_vote_full, i_clk, i_rst_n, r_state == S_VOTE |-> r_fill == FILL_W'(WINDOW), "vote with partial window")
    `WMVF_ASSERT(a_none_zero, i_clk, i_rst_n, (o_out_valid && o_result_kind == KIND_NONE) |-> o_voted_class == '0, "none result carries a class")
    `WMVF_ASSERT(a_seen_no_result, i_clk, i_rst_n, (in_acc && i_func == FUNC_REPORT && i_object_count != '0) |=> r_state == S_IDLE, "result after objects seen")

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import wmvf_pkg::*;

    localparam int WINDOW        = 10;
    localparam int NUM_CLASSES   = 11;
    localparam int SETTLE_CYCLES = WINDOW + NUM_CLASSES + 10;
    localparam int STUCK_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 80;
    localparam int MAX_PRINTS    = 40;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [CLASS_W-1:0] cls;
    } t_vote_result;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic [FUNC_W-1:0]  i_func         = '0;
    logic [CLASS_W-1:0] i_class_id     = '0;
    logic [COUNT_W-1:0] i_object_count = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic               o_result_kind;
    logic [CLASS_W-1:0] o_voted_class;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [IDLE_W-1:0]  i_cfg_data     = '0;

    windowed_mode_vote_filter_unit #(
        .WINDOW      (WINDOW),
        .NUM_CLASSES (NUM_CLASSES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_class_id     (i_class_id),
        .i_object_count (i_object_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_voted_class  (o_voted_class),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // Shadow state of the filter
    logic [CLASS_W-1:0] shadow_window [WINDOW];
    int                 shadow_fill;
    logic [IDLE_W-1:0]  shadow_idle;
    logic [IDLE_W-1:0]  shadow_timeout;

    t_vote_result       pending_votes [$];
    t_vote_result       got_vote;
    t_vote_result       want_vote;
    int                 mismatch_count = 0;
    int                 stuck_cycles   = 0;

    // Sender burst control
    bit                 sender_gaps  = 1'b1;
    int                 burst_left   = 0;
    logic [IDLE_W-1:0]  cur_timeout  = TIMEOUT_RESET;

    // Receiver stall pattern
    int                 stall_mode   = 0;
    int                 mode_timer   = 0;
    int                 run_left     = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTS) begin
            $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Mode of the window, lowest class on a tie
    function automatic logic [CLASS_W-1:0] window_mode();
        int tally [NUM_CLASSES];
        int best;
        int k;
        foreach (tally[k]) tally[k] = 0;
        for (k = 0; k < WINDOW; k++) begin
            if (shadow_window[k] < NUM_CLASSES) tally[shadow_window[k]]++;
        end
        best = 0;
        for (k = 1; k < NUM_CLASSES; k++) begin
            if (tally[k] > tally[best]) best = k;
        end
        return CLASS_W'(best);
    endfunction

    // Advance the shadow state by one accepted beat
    task automatic predict_beat(input logic [FUNC_W-1:0] fn, input logic [CLASS_W-1:0] cls,
                                input logic [COUNT_W-1:0] cnt);
        t_vote_result r;
        int k;
        case (fn)
            FUNC_DET: begin
                if (cls < ACCEPT_LIMIT) begin
                    for (k = 0; k < WINDOW - 1; k++) shadow_window[k] = shadow_window[k + 1];
                    shadow_window[WINDOW - 1] = cls;
                    if (shadow_fill < WINDOW) shadow_fill++;
                    if (shadow_fill >= WINDOW) begin
                        r.kind = KIND_VOTE;
                        r.cls  = window_mode();
                        pending_votes = {pending_votes, r};
                    end
                end
            end
            FUNC_REPORT: begin
                if (cnt != '0) shadow_idle = '0;
                if (shadow_idle > shadow_timeout) begin
                    r.kind = KIND_NONE;
                    r.cls  = '0;
                    pending_votes = {pending_votes, r};
                end
            end
            FUNC_TICK: begin
                if (shadow_idle < IDLE_MAX) shadow_idle = shadow_idle + 1'b1;
            end
            default: ;
        endcase
    endtask

    // Check results, track config and input beats, count stuck cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_window[k]) shadow_window[k] = '0;
            shadow_fill    = 0;
            shadow_idle    = '0;
            shadow_timeout = TIMEOUT_RESET;
            stuck_cycles   = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_vote.kind = o_result_kind;
                got_vote.cls  = o_voted_class;
                if (pending_votes.size() == 0) begin
                    report_mismatch("result with nothing pending, class", got_vote.cls, 0);
                end else begin
                    want_vote = pending_votes.pop_front();
                    if (got_vote.kind !== want_vote.kind)
                        report_mismatch("result_kind", got_vote.kind, want_vote.kind);
                    if (got_vote.cls !== want_vote.cls)
                        report_mismatch("voted_class", got_vote.cls, want_vote.cls);
                end
            end
            if (i_cfg_valid && o_cfg_ready) shadow_timeout = i_cfg_data;
            if (i_in_valid && !o_in_stall) predict_beat(i_func, i_class_id, i_object_count);
            if ((o_out_valid && !i_out_stall) || (i_cfg_valid && o_cfg_ready) ||
                (i_in_valid && !o_in_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("tb NOT OK");
        $finish;
    end

    // Receiver stall: free running, random, or long runs
    always @(posedge i_clk) begin
        if (mode_timer == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_timer <= $urandom_range(50, 300);
        end else begin
            mode_timer <= mode_timer - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (run_left == 0) begin
                    run_left    <= $urandom_range(1, 16);
                    i_out_stall <= !i_out_stall;
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    // Send one beat; gaps fall between bursts
    task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [CLASS_W-1:0] cls,
                             input logic [COUNT_W-1:0] cnt);
        if (sender_gaps && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid     <= 1'b1;
        i_func         <= fn;
        i_class_id     <= cls;
        i_object_count <= cnt;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Hold off until every result is in and the engine has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_votes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [IDLE_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_timeout = value;
    endtask

    // Fill the window, tie to the lowest class, ignored ids and func codes
    task automatic test_fill_and_tie();
        int k;
        for (k = 0; k < 5; k++) send_beat(FUNC_DET, 4'd4, 8'd0);
        for (k = 0; k < 5; k++) send_beat(FUNC_DET, 4'd1, 8'd0);
        send_beat(FUNC_DET, 4'd15, 8'hFF);
        send_beat(FUNC_DET, ACCEPT_LIMIT, 8'h00);
        send_beat(FUNC_UNUSED, 4'd2, 8'hAA);
        send_beat(FUNC_DET, 4'd0, 8'h55);
        send_beat(FUNC_DET, 4'd3, 8'd0);
        drain();
    endtask

    // Timeout at both extremes, count reports with and without objects
    task automatic test_timeout_extremes();
        send_beat(FUNC_REPORT, 4'd0, 8'd0);
        write_timeout(16'd0);
        send_beat(FUNC_TICK, 4'd0, 8'd0);
        send_beat(FUNC_REPORT, 4'd0, 8'd0);
        send_beat(FUNC_REPORT, 4'd9, 8'd255);
        send_beat(FUNC_REPORT, 4'd0, 8'd0);
        send_beat(FUNC_TICK, 4'd0, 8'd0);
        send_beat(FUNC_REPORT, 4'd0, 8'd1);
        write_timeout(IDLE_MAX);
        send_beat(FUNC_TICK, 4'd0, 8'd0);
        send_beat(FUNC_REPORT, 4'd0, 8'd0);
        drain();
    endtask

    // Long tick run up to the timeout, then one tick past it
    task automatic test_long_idle();
        int k;
        write_timeout(16'd40);
        sender_gaps = 1'b0;
        for (k = 0; k < 40; k++) send_beat(FUNC_TICK, 4'd0, 8'd0);
        send_beat(FUNC_REPORT, 4'd0, 8'd0);
        send_beat(FUNC_TICK, 4'd0, 8'd0);
        send_beat(FUNC_REPORT, 4'd0, 8'd0);
        send_beat(FUNC_REPORT, 4'd0, 8'd128);
        send_beat(FUNC_REPORT, 4'd0, 8'd0);
        sender_gaps = 1'b1;
        drain();
    endtask

    // Random mix: votes, tick runs ending in empty reports, noise
    task automatic test_random_traffic();
        logic [IDLE_W-1:0] phase_timeout [6];
        int phase;
        int items;
        int pick;
        int run_len;
        int k;
        phase_timeout[0] = TIMEOUT_RESET;
        phase_timeout[1] = 16'd0;
        phase_timeout[2] = IDLE_W'($urandom_range(1, 12));
        phase_timeout[3] = IDLE_MAX;
        phase_timeout[4] = IDLE_W'($urandom_range(1, 3));
        phase_timeout[5] = IDLE_W'($urandom_range(4, 15));
        for (phase = 0; phase < 6; phase++) begin
            write_timeout(phase_timeout[phase]);
            sender_gaps = ($urandom_range(0, 3) != 0);
            items = 0;
            while (items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_beat(FUNC_DET, CLASS_W'($urandom_range(0, 4)), COUNT_W'($urandom));
                    items++;
                end else if (pick < 58) begin
                    send_beat(FUNC_DET, CLASS_W'($urandom_range(0, 15)), COUNT_W'($urandom));
                end else if (pick < 70) begin
                    run_len = (cur_timeout < 20) ? $urandom_range(0, cur_timeout + 3)
                                                 : $urandom_range(0, 12);
                    for (k = 0; k < run_len; k++)
                        send_beat(FUNC_TICK, CLASS_W'($urandom), COUNT_W'($urandom));
                    send_beat(FUNC_REPORT, CLASS_W'($urandom), 8'd0);
                    items += run_len + 1;
                end else if (pick < 80) begin
                    send_beat(FUNC_TICK, CLASS_W'($urandom), COUNT_W'($urandom));
                    items++;
                end else if (pick < 94) begin
                    send_beat(FUNC_REPORT, CLASS_W'($urandom),
                              ($urandom_range(0, 1) == 0) ? 8'd0 : COUNT_W'($urandom));
                    items++;
                end else if (pick < 98) begin
                    send_beat(FUNC_UNUSED, CLASS_W'($urandom), COUNT_W'($urandom));
                end else begin
                    drain();
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_and_tie();
        test_timeout_extremes();
        test_long_idle();
        test_random_traffic();
        drain();
        if (mismatch_count == 0 && pending_votes.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// File: windowed_mode_vote_filter_unit.f
+incdir+rtl/core
rtl/core/wmvf_pkg.sv
rtl/core/wmvf_vote.sv
rtl/core/windowed_mode_vote_filter_unit.sv
verif/tb.sv
